[sv/mrfs_pkg.sv]
`timescale 1ns / 1ps

package mrfs_pkg;

  localparam int RegDepth = 256;

  localparam logic [2:0] OP_SET_PTR = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_ENC_A   = 3'd3;
  localparam logic [2:0] OP_ENC_B   = 3'd4;

  localparam logic [7:0] DIR_ADDR   = 8'h01;
  localparam logic [7:0] DUTY_ADDR  = 8'h02;
  localparam logic [7:0] COUNT_ADDR = 8'h20;

  localparam logic [7:0] DIR_REV   = 8'd0;
  localparam logic [7:0] DIR_FWD   = 8'd1;
  localparam logic [7:0] DIR_BRAKE = 8'd2;

  localparam logic [31:0] COUNT_RESET = 32'd5;
  localparam logic [7:0]  PWM_TOP     = 8'd255;

  // Drive latch order is {green, red, rev, fwd}.
  localparam logic [3:0] DRIVE_FWD   = 4'b1001;
  localparam logic [3:0] DRIVE_REV   = 4'b0110;
  localparam logic [3:0] DRIVE_BRAKE = 4'b0011;

endpackage

[sv/motor_register_file_slave.sv]
`timescale 1ns / 1ps

// Byte register file with an H-bridge drive latch and a quadrature counter.
// A transaction is accepted at a rising clock edge with start high and busy
// low; busy is always low, so one transaction can be accepted every cycle.
// Op codes set the byte pointer, write or read the byte at the pointer (both
// post-increment the pointer, wrapping at the end of the store), or count an
// encoder A or B edge. Every accepted transaction gives exactly one result,
// shown on the result ports in the cycle after the accept edge, with done
// high for a single cycle, and the throughput is one per cycle.
// The result carries the byte read (zero for other ops), the bridge and lamp
// levels from the direction byte, and the compare value 255 minus the duty.
// The direction, duty and count bytes are held in flip-flops; the other bytes
// sit in a RAM whose read port is registered.
// The receiver cannot stall: each result is taken at the edge that ends it.
// A synchronous reset clears the pointer, the drive latch and the whole store
// at once (valid bits for the RAM), and loads the encoder count with five.
module motor_register_file_slave
  import mrfs_pkg::*;
#(
  parameter int REG_DEPTH = RegDepth,
  localparam int AW = $clog2(REG_DEPTH)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] data,
  input  logic       enc_a,
  input  logic       enc_b,
  output logic       done,
  output logic [7:0] read_data,
  output logic       fwd_drive,
  output logic       rev_drive,
  output logic       led_red,
  output logic       green_led,
  output logic [7:0] pwm_compare
);

  localparam logic [AW-1:0] DIR_A   = AW'(DIR_ADDR);
  localparam logic [AW-1:0] DUTY_A  = AW'(DUTY_ADDR);
  localparam logic [AW-1:0] COUNT_A = AW'(COUNT_ADDR);

  logic            accept;
  logic [AW-1:0]   pointer;
  logic [AW-1:0]   pointer_next;
  logic [7:0]      dir;
  logic [7:0]      dir_next;
  logic [7:0]      duty;
  logic [7:0]      duty_next;
  logic [31:0]     count;
  logic [31:0]     count_next;
  logic [3:0]      drive;
  logic [3:0]      drive_next;
  logic            is_write;
  logic            is_read;
  logic            at_count;
  logic            special;
  logic [7:0]      special_byte;
  logic            rd_pending;
  logic            rd_special;
  logic [7:0]      rd_special_byte;
  logic [7:0]      ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_write = accept && (op == OP_WRITE);
  assign is_read  = accept && (op == OP_READ);
  assign at_count = (pointer[AW-1:2] == COUNT_A[AW-1:2]);
  assign special  = (pointer == DIR_A) || (pointer == DUTY_A) || at_count;

  always_comb begin
    if (pointer == DIR_A) begin
      special_byte = dir;
    end else if (pointer == DUTY_A) begin
      special_byte = duty;
    end else begin
      special_byte = count[8 * pointer[1:0] +: 8];
    end
  end

  always_comb begin
    pointer_next = pointer;
    dir_next     = dir;
    duty_next    = duty;
    count_next   = count;
    if (accept) begin
      case (op)
        OP_SET_PTR: pointer_next = data[AW-1:0];
        OP_WRITE: begin
          pointer_next = pointer + AW'(1);
          if (pointer == DIR_A) begin
            dir_next = data;
          end
          if (pointer == DUTY_A) begin
            duty_next = data;
          end
          if (at_count) begin
            count_next[8 * pointer[1:0] +: 8] = data;
          end
        end
        OP_READ: pointer_next = pointer + AW'(1);
        OP_ENC_A: count_next = (enc_a == enc_b) ? count - 32'd1 : count + 32'd1;
        OP_ENC_B: count_next = (enc_a == enc_b) ? count + 32'd1 : count - 32'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    drive_next = drive;
    if (accept) begin
      unique case (dir_next)
        DIR_FWD:   drive_next = DRIVE_FWD;
        DIR_REV:   drive_next = DRIVE_REV;
        DIR_BRAKE: drive_next = DRIVE_BRAKE;
        default:   drive_next = drive;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer    <= '0;
      dir        <= '0;
      duty       <= '0;
      count      <= COUNT_RESET;
      drive      <= '0;
      done       <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      pointer    <= pointer_next;
      dir        <= dir_next;
      duty       <= duty_next;
      count      <= count_next;
      drive      <= drive_next;
      done       <= accept;
      rd_pending <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_special      <= special;
      rd_special_byte <= special_byte;
    end
  end

  mrfs_byte_ram #(
    .DEPTH(REG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (is_write),
    .re    (is_read),
    .addr  (pointer),
    .wdata (data),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!rd_pending) begin
      read_data = 8'd0;
    end else if (rd_special) begin
      read_data = rd_special_byte;
    end else begin
      read_data = ram_rdata;
    end
  end

  assign fwd_drive   = drive[0];
  assign rev_drive   = drive[1];
  assign led_red     = drive[2];
  assign green_led   = drive[3];
  assign pwm_compare = PWM_TOP - duty;

endmodule

[sv/mrfs_byte_ram.sv]
`timescale 1ns / 1ps

module mrfs_byte_ram
  import mrfs_pkg::*;
#(
  parameter int DEPTH = RegDepth,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        valid_q <= valid[addr];
      end
    end
  end

  assign rdata = valid_q ? mem_q : 8'd0;

endmodule
